### rtl/core/ffsa_pkg.sv
// package: constants and types of the first-fit segment allocator
package ffsa_pkg;
	localparam int TABLE_ENTRIES   = 64;
	localparam int MIN_SPLIT_BYTES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] REQ_ALLOC    = 2'd0;
	localparam logic [1:0] REQ_FREE     = 2'd1;
	localparam logic [1:0] REQ_COALESCE = 2'd2;
	localparam logic [1:0] REQ_UNUSED   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
	localparam logic [2:0] ST_BAD_FREE  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NO_HEAP   = 3'd4;

	localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
	localparam logic [1:0] CFG_GROW_SIZE  = 2'd1;
	localparam logic [1:0] CFG_HEAP_LIMIT = 2'd2;

	localparam logic [30:0] GROW_RESET = 31'd8192;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [30:0] request_bytes;
		logic [31:0] free_addr;
		logic [31:0] header_size;
		logic [31:0] header_check;
	} req_word_t;

	typedef struct packed {
		logic [31:0] user_addr;
		logic [31:0] chunk_bytes;
		logic [31:0] check_word;
		logic [2:0]  status;
	} rsp_word_t;

	// one table entry
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} seg_t;
endpackage

### rtl/core/ffsa_if.sv
// valid/ready channel interfaces for requests and results
interface ffsa_req_if;
	logic valid;
	logic ready;
	ffsa_pkg::req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ffsa_rsp_if;
	logic valid;
	logic ready;
	ffsa_pkg::rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ffsa_seg_ram.sv
// segment table memory, one write port and one registered read port
module ffsa_seg_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ffsa_pkg::IDX_W-1:0] waddr,
	input  ffsa_pkg::seg_t            wdata,
	input  logic [ffsa_pkg::IDX_W-1:0] raddr,
	output ffsa_pkg::seg_t            rdata
);
	ffsa_pkg::seg_t mem [ffsa_pkg::TABLE_ENTRIES];

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/first_fit_segment_allocator_core.sv
// top level of the first-fit segment allocator
//  channel | dir | handshake     | word
//  req     | in  | valid/ready   | req_type, request_bytes, free_addr, header_size, header_check
//  rsp     | out | valid/ready   | user_addr, chunk_bytes, check_word, status
//  cfg     | in  | cfg_we only   | cfg_index, cfg_data
// one request at a time; the sequencer reads the table through one
// registered read port, visiting the entries one after another; an insert or
// removal shifts the entries behind it. a growing allocate at worst does scan,
// insert, scan and removal.
// a coalesce shifts the tail down once per merge.
// reset empties the table by clearing the count, no clearing pass.
// the result sits in an output register; a stall there holds the next result in done.
module first_fit_segment_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	ffsa_req_if.sink      req,
	ffsa_rsp_if.source    rsp
);
	localparam int IW = ffsa_pkg::IDX_W;
	localparam int CW = ffsa_pkg::CNT_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(ffsa_pkg::TABLE_ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_FIT_RD, S_FIT_CHK, S_DROP_RD, S_DROP_WR,
		S_GROW, S_INS_RD, S_INS_CHK, S_SHF_RD, S_SHF_WR, S_INS_PUT,
		S_MRG_RD, S_MRG_CHK, S_DONE
	} state_t;

	state_t state_q;
	logic [31:0] heap_limit_q, heap_top_q;
	logic [30:0] grow_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q, pos_q;
	ffsa_pkg::req_word_t req_q;
	logic [33:0] chunk_q;
	logic retry_q;
	logic ins_free_q;
	ffsa_pkg::seg_t ins_q, prev_q;
	logic [31:0] where_q;
	ffsa_pkg::rsp_word_t rsp_q;
	ffsa_pkg::rsp_word_t rsp_out_q;
	logic rsp_valid_q;

	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	ffsa_pkg::seg_t ram_wdata, ram_rdata;

	ffsa_seg_ram u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// growth amount
	logic [33:0] grow_amt;
	logic [33:0] grow_ext;
	logic [33:0] new_top;
	always_comb begin
		grow_ext = {3'd0, grow_q};
		if (grow_ext >= chunk_q + 34'(ffsa_pkg::MIN_SPLIT_BYTES)) begin
			grow_amt = grow_ext;
		end else if (grow_ext <= chunk_q) begin
			grow_amt = chunk_q;
		end else begin
			grow_amt = grow_ext + 34'd8;
		end
		new_top = {2'd0, heap_top_q} + grow_amt;
	end

	// merge test
	logic [32:0] mrg_end, mrg_sum;
	assign mrg_end = {1'b0, prev_q.start} + {1'b0, prev_q.length};
	assign mrg_sum = {1'b0, prev_q.length} + {1'b0, ram_rdata.length};

	logic [33:0] req_chunk;
	assign req_chunk = 34'd8 + {3'd0, req.data.request_bytes}
		+ {31'd0, (3'd0 - req.data.request_bytes[2:0])};

	// coalesce walk resumes after a drop; result loads when the output is free
	logic mrg_again, rsp_load;
	assign mrg_again = (req_q.req_type == ffsa_pkg::REQ_COALESCE) && (chunk_q == '1) &&
		retry_q;
	assign rsp_load = (state_q == S_DONE) && !mrg_again && (!rsp_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_out_q;

	// memory port drive
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = i_q[IW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = i_q[IW-1:0];
		case (state_q)
			S_IDLE: ram_raddr = '0;
			S_FIT_CHK: begin
				if ({2'd0, ram_rdata.length} != chunk_q &&
						{2'd0, ram_rdata.length} >=
						chunk_q + 34'(ffsa_pkg::MIN_SPLIT_BYTES)) begin
					ram_we = 1'b1;
					ram_wdata.start = ram_rdata.start + chunk_q[31:0];
					ram_wdata.length = ram_rdata.length - chunk_q[31:0];
				end
			end
			S_DROP_WR: begin
				ram_we = 1'b1;
				ram_waddr = IW'(i_q - CW'(1));
			end
			S_SHF_RD: ram_raddr = IW'(i_q - CW'(1));
			S_SHF_WR: ram_we = 1'b1;
			S_INS_PUT: begin
				ram_we = 1'b1;
				ram_waddr = pos_q[IW-1:0];
				ram_wdata = ins_q;
			end
			S_MRG_CHK: begin
				ram_we = (mrg_end == {1'b0, ram_rdata.start}) && !mrg_sum[32];
				ram_waddr = IW'(i_q - CW'(1));
				ram_wdata.start = prev_q.start;
				ram_wdata.length = mrg_sum[31:0];
			end
			default: ;
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			heap_top_q <= '0;
			heap_limit_q <= '1;
			grow_q <= ffsa_pkg::GROW_RESET;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					ffsa_pkg::CFG_HEAP_BASE: heap_top_q <= cfg_data;
					ffsa_pkg::CFG_GROW_SIZE: grow_q <= cfg_data[30:0];
					ffsa_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						chunk_q <= req_chunk;
						retry_q <= 1'b0;
						rsp_q <= '0;
						i_q <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (req_q.req_type)
						ffsa_pkg::REQ_ALLOC: begin
							if (req_q.request_bytes == '0) begin
								rsp_q.status <= ffsa_pkg::ST_ZERO_SIZE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_FIT_RD;
							end
						end
						ffsa_pkg::REQ_FREE: begin
							if (req_q.free_addr < 32'd8 ||
									req_q.header_check != ~req_q.header_size) begin
								rsp_q.status <= ffsa_pkg::ST_BAD_FREE;
								state_q <= S_DONE;
							end else if (count_q >= FULL_CNT) begin
								rsp_q.status <= ffsa_pkg::ST_FULL;
								state_q <= S_DONE;
							end else begin
								ins_q.start <= req_q.free_addr - 32'd8;
								ins_q.length <= req_q.header_size;
								ins_free_q <= 1'b1;
								state_q <= S_INS_RD;
							end
						end
						ffsa_pkg::REQ_COALESCE: begin
							i_q <= CW'(1);
							state_q <= (count_q > CW'(1)) ? S_MRG_RD : S_DONE;
							prev_q <= ram_rdata;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_FIT_RD: begin
					state_q <= (i_q < count_q) ? S_FIT_CHK : S_GROW;
				end
				S_FIT_CHK: begin
					if ({2'd0, ram_rdata.length} == chunk_q) begin
						where_q <= ram_rdata.start;
						i_q <= i_q + CW'(1);
						state_q <= S_DROP_RD;
					end else if ({2'd0, ram_rdata.length} >=
							chunk_q + 34'(ffsa_pkg::MIN_SPLIT_BYTES)) begin
						where_q <= ram_rdata.start;
						rsp_q.user_addr <= ram_rdata.start + 32'd8;
						rsp_q.chunk_bytes <= chunk_q[31:0];
						rsp_q.check_word <= ~chunk_q[31:0];
						state_q <= S_DONE;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_FIT_RD;
					end
				end
				S_DROP_RD: begin
					if (i_q < count_q) begin
						state_q <= S_DROP_WR;
					end else begin
						count_q <= count_q - CW'(1);
						if (req_q.req_type != ffsa_pkg::REQ_COALESCE) begin
							rsp_q.user_addr <= where_q + 32'd8;
							rsp_q.chunk_bytes <= chunk_q[31:0];
							rsp_q.check_word <= ~chunk_q[31:0];
						end
						state_q <= S_DONE;
					end
				end
				S_DROP_WR: begin
					i_q <= i_q + CW'(1);
					state_q <= S_DROP_RD;
				end
				S_GROW: begin
					if (retry_q) begin
						rsp_q.status <= ffsa_pkg::ST_NO_HEAP;
						state_q <= S_DONE;
					end else if (count_q >= FULL_CNT) begin
						rsp_q.status <= ffsa_pkg::ST_FULL;
						state_q <= S_DONE;
					end else if (new_top > {2'd0, heap_limit_q}) begin
						rsp_q.status <= ffsa_pkg::ST_NO_HEAP;
						state_q <= S_DONE;
					end else begin
						ins_q.start <= heap_top_q;
						ins_q.length <= grow_amt[31:0];
						heap_top_q <= new_top[31:0];
						ins_free_q <= 1'b0;
						retry_q <= 1'b1;
						i_q <= '0;
						state_q <= S_INS_RD;
					end
				end
				// find insert position, append at the end when none is larger
				S_INS_RD: begin
					if (i_q < count_q) begin
						state_q <= S_INS_CHK;
					end else begin
						pos_q <= i_q;
						state_q <= S_SHF_RD;
					end
				end
				S_INS_CHK: begin
					if (ram_rdata.start <= ins_q.start) begin
						i_q <= i_q + CW'(1);
						state_q <= S_INS_RD;
					end else begin
						pos_q <= i_q;
						i_q <= count_q;
						state_q <= S_SHF_RD;
					end
				end
				S_SHF_RD: state_q <= S_SHF_WR;
				S_SHF_WR: begin
					if (i_q <= pos_q || i_q == '0) begin
						state_q <= S_INS_PUT;
					end else begin
						i_q <= i_q - CW'(1);
						state_q <= S_SHF_RD;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					if (ins_free_q) begin
						state_q <= S_DONE;
					end else begin
						i_q <= '0;
						state_q <= S_FIT_RD;
					end
				end
				// walk adjacent pairs
				S_MRG_RD: state_q <= (i_q < count_q) ? S_MRG_CHK : S_DONE;
				S_MRG_CHK: begin
					if (mrg_end == {1'b0, ram_rdata.start} && !mrg_sum[32]) begin
						prev_q.length <= mrg_sum[31:0];
						pos_q <= i_q;
						// remove entry i by shifting down, reuse drop loop
						i_q <= i_q + CW'(1);
						state_q <= S_DROP_RD;
						retry_q <= 1'b1;
						chunk_q <= '1;
					end else begin
						prev_q <= ram_rdata;
						i_q <= i_q + CW'(1);
						state_q <= S_MRG_RD;
					end
				end
				S_DONE: begin
					if (mrg_again) begin
						retry_q <= 1'b0;
						i_q <= pos_q;
						state_q <= S_MRG_RD;
					end else if (rsp_load) begin
						rsp_out_q <= rsp_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// the table never holds more than its depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("segment count overflow");
	// a waiting result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_out_q))
		else $error("result word changed while waiting");
	// a result appears only from the done step
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE) else $error("stray result");
`endif
endmodule
